// ===== sv/lpct_pkg.sv =====
// ----------------------------------------------------------------------------
// lpct_pkg
// Shared types and constants for the linear probing count table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpct_pkg;

    localparam int unsigned KEY_W     = 64;
    localparam int unsigned HASH_W    = 64;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned SLOT_W    = 10;
    localparam int unsigned S_TDATA_W = KEY_W + HASH_W;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned M_TUSER_W = 2;

    localparam logic [KEY_W-1:0]   MARKER_RESET = 64'h3F3F_3F3F_3F3F_3F3F;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_ONE    = 16'd1;

    localparam logic ACTION_INCR  = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam int unsigned MOD_STEP   = 8;
    localparam int unsigned MOD_CYCLES = HASH_W / MOD_STEP;
    localparam int unsigned MOD_CNT_W  = $clog2(MOD_CYCLES + 3);
    localparam logic [MOD_CNT_W-1:0] MOD_MUL  = MOD_CNT_W'(MOD_CYCLES);
    localparam logic [MOD_CNT_W-1:0] MOD_SUB  = MOD_CNT_W'(MOD_CYCLES + 1);
    localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_CYCLES + 2);

    typedef struct packed {
        logic load_item;
        logic mod_start;
        logic pos_load;
        logic probe_next;
        logic commit;
        logic set_full;
        logic sweep;
        logic fill_const;
        logic res_clear;
        logic out_load;
    } lpct_cmd_t;

    typedef struct packed {
        logic mod_done;
        logic is_empty;
        logic is_match;
        logic last_probe;
        logic pos_last;
        logic out_free;
    } lpct_sts_t;

endpackage

`default_nettype wire

// ===== sv/lpct_mod.sv =====
// ----------------------------------------------------------------------------
// lpct_mod
// Reduction of the hash code modulo the table size. A power-of-two size
// takes the low bits, registered; any other size folds the hash a byte a
// cycle with constant byte weights, then reduces the sum by reciprocal
// multiplication and one compare and subtract.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpct_mod
    import lpct_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 1024,
    localparam int unsigned AW = $clog2(NUM_SLOTS)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start_i,
    input  wire logic [HASH_W-1:0] hash_i,
    output logic                   done_o,
    output logic [AW-1:0]          rem_o
);

    localparam bit IS_POW2 = ((NUM_SLOTS & (NUM_SLOTS - 1)) == 0);

    function automatic logic [AW-1:0] digit_weight(input int unsigned idx);
        logic [AW:0] w;
        w = (AW + 1)'(1);
        for (int unsigned k = 0; k < MOD_STEP * idx; k++) begin
            w = {w[AW-1:0], 1'b0};
            if (w >= (AW + 1)'(NUM_SLOTS)) begin
                w = w - (AW + 1)'(NUM_SLOTS);
            end
        end
        return w[AW-1:0];
    endfunction

    generate
        if (IS_POW2) begin : g_pow2
            logic          done_reg;
            logic [AW-1:0] rem_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start_i;
                end
            end

            always_ff @(posedge aclk) begin
                if (start_i) begin
                    rem_reg <= hash_i[AW-1:0];
                end
            end

            assign done_o = done_reg;
            assign rem_o  = rem_reg;
        end else begin : g_iter
            localparam int unsigned DIG_W = $clog2(MOD_CYCLES);
            localparam int unsigned ACC_W = AW + MOD_STEP + DIG_W;
            localparam logic [AW:0]      MODULUS = (AW + 1)'(NUM_SLOTS);
            localparam logic [ACC_W-1:0] MOD_ACC = ACC_W'(NUM_SLOTS);
            localparam logic [ACC_W-1:0] RECIP   = ACC_W'((64'd1 << ACC_W) / NUM_SLOTS);

            logic                 busy_reg;
            logic                 done_reg;
            logic [MOD_CNT_W-1:0] cnt_reg;
            logic [HASH_W-1:0]    shift_reg;
            logic [ACC_W-1:0]     acc_reg;
            logic [2*ACC_W-1:0]   prod_reg;
            logic [AW:0]          diff_reg;
            logic [AW-1:0]        rem_reg;
            logic [AW-1:0]        weight [MOD_CYCLES];
            logic [ACC_W-1:0]     term;
            logic [ACC_W-1:0]     diff_wide;
            logic [AW:0]          diff_fix;

            for (genvar g = 0; g < MOD_CYCLES; g++) begin : g_weight
                assign weight[g] = digit_weight(g);
            end

            assign term      = ACC_W'(shift_reg[MOD_STEP-1:0])
                             * ACC_W'(weight[cnt_reg[DIG_W-1:0]]);
            assign diff_wide = acc_reg - prod_reg[2*ACC_W-1:ACC_W] * MOD_ACC;
            assign diff_fix  = (diff_reg >= MODULUS) ? diff_reg - MODULUS : diff_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end else begin
                    done_reg <= 1'b0;
                    if (start_i) begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= '0;
                    end else if (busy_reg) begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == MOD_LAST) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (start_i) begin
                    shift_reg <= hash_i;
                    acc_reg   <= '0;
                end else if (busy_reg) begin
                    if (cnt_reg < MOD_MUL) begin
                        shift_reg <= shift_reg >> MOD_STEP;
                        acc_reg   <= acc_reg + term;
                    end
                    if (cnt_reg == MOD_MUL) begin
                        prod_reg <= (2 * ACC_W)'(acc_reg) * (2 * ACC_W)'(RECIP);
                    end
                    if (cnt_reg == MOD_SUB) begin
                        diff_reg <= diff_wide[AW:0];
                    end
                    if (cnt_reg == MOD_LAST) begin
                        rem_reg <= diff_fix[AW-1:0];
                    end
                end
            end

            assign done_o = done_reg;
            assign rem_o  = rem_reg;
        end
    endgenerate

endmodule

`default_nettype wire

// ===== sv/lpct_dp.sv =====
// ----------------------------------------------------------------------------
// lpct_dp
// Datapath: key and count memories, probe position, compare, result and
// output registers, empty-marker register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpct_dp
    import lpct_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 1024,
    localparam int unsigned AW = $clog2(NUM_SLOTS)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wen,
    input  wire logic [KEY_W-1:0]     cfg_wdata,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [M_TUSER_W-1:0]      m_tuser,
    input  wire lpct_cmd_t            cmd_i,
    output lpct_sts_t                 sts_o
);

    localparam logic [AW-1:0] POS_LAST = AW'(NUM_SLOTS - 1);

    logic [KEY_W-1:0]   key_mem [NUM_SLOTS];
    logic [COUNT_W-1:0] cnt_mem [NUM_SLOTS];

    logic [KEY_W-1:0]   marker_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [AW-1:0]      pos_reg;
    logic [AW-1:0]      tries_reg;
    logic [KEY_W-1:0]   key_q_reg;
    logic [COUNT_W-1:0] cnt_q_reg;

    logic               res_status_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic [COUNT_W-1:0] res_count_reg;
    logic               res_new_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    logic               mod_done;
    logic [AW-1:0]      mod_rem;
    logic [AW-1:0]      pos_inc;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [KEY_W-1:0]   wr_key;
    logic [COUNT_W-1:0] wr_cnt;
    logic [COUNT_W-1:0] cnt_bumped;
    logic [SLOT_W-1:0]  slot_idx;
    logic               is_empty;
    logic               is_match;

    lpct_mod #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (cmd_i.mod_start),
        .hash_i  (s_tdata[S_TDATA_W-1:KEY_W]),
        .done_o  (mod_done),
        .rem_o   (mod_rem)
    );

    generate
        if (AW >= SLOT_W) begin : g_slot_cut
            assign slot_idx = pos_reg[SLOT_W-1:0];
        end else begin : g_slot_ext
            assign slot_idx = {{(SLOT_W - AW){1'b0}}, pos_reg};
        end
    endgenerate

    assign pos_inc    = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
    assign is_empty   = (key_q_reg == marker_reg);
    assign is_match   = (key_q_reg == key_reg);
    assign cnt_bumped = (cnt_q_reg == COUNT_MAX) ? COUNT_MAX : cnt_q_reg + 1'b1;

    always_comb begin
        priority if (cmd_i.pos_load) begin
            rd_addr = mod_rem;
        end else if (cmd_i.probe_next) begin
            rd_addr = pos_inc;
        end else begin
            rd_addr = pos_reg;
        end
    end

    always_comb begin
        mem_we = cmd_i.sweep | cmd_i.commit;
        wr_key = key_reg;
        wr_cnt = is_empty ? COUNT_ONE : cnt_bumped;
        if (cmd_i.sweep) begin
            wr_key = cmd_i.fill_const ? MARKER_RESET : marker_reg;
            wr_cnt = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[pos_reg] <= wr_key;
            cnt_mem[pos_reg] <= wr_cnt;
        end
        key_q_reg <= key_mem[rd_addr];
        cnt_q_reg <= cnt_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg <= MARKER_RESET;
        end else if (cfg_wen) begin
            marker_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (cmd_i.load_item) begin
            pos_reg <= '0;
        end else if (cmd_i.pos_load) begin
            pos_reg <= mod_rem;
        end else if (cmd_i.probe_next || cmd_i.sweep) begin
            pos_reg <= pos_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_item) begin
            key_reg <= s_tdata[KEY_W-1:0];
        end
        if (cmd_i.pos_load) begin
            tries_reg <= '0;
        end else if (cmd_i.probe_next) begin
            tries_reg <= tries_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.commit) begin
            res_status_reg <= STATUS_OK;
            res_slot_reg   <= slot_idx;
            res_count_reg  <= wr_cnt;
            res_new_reg    <= is_empty;
        end else if (cmd_i.set_full) begin
            res_status_reg <= STATUS_FULL;
            res_slot_reg   <= '0;
            res_count_reg  <= '0;
            res_new_reg    <= 1'b0;
        end else if (cmd_i.res_clear) begin
            res_status_reg <= STATUS_OK;
            res_slot_reg   <= '0;
            res_count_reg  <= '0;
            res_new_reg    <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd_i.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.out_load) begin
            m_tdata_reg <= M_TDATA_W'({res_count_reg, res_slot_reg});
            m_tuser_reg <= {res_new_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        sts_o.mod_done   = mod_done;
        sts_o.is_empty   = is_empty;
        sts_o.is_match   = is_match;
        sts_o.last_probe = (tries_reg == POS_LAST);
        sts_o.pos_last   = (pos_reg == POS_LAST);
        sts_o.out_free   = !m_tvalid_reg || m_tready;
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an item still waiting");

    a_commit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.commit |=> (res_count_reg != '0) && (res_status_reg == STATUS_OK))
        else $error("committed slot has zero count");

    a_new_is_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.commit && is_empty) |=> (res_new_reg && res_count_reg == COUNT_ONE))
        else $error("new entry does not start at one");

    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.set_full |=> (res_slot_reg == '0 && res_count_reg == '0 && !res_new_reg))
        else $error("full result carries a slot");

endmodule

`default_nettype wire

// ===== sv/lpct_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpct_ctrl
// Controller: reset sweep, item intake, hash reduction wait, probe loop,
// clear sweep and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpct_ctrl
    import lpct_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire logic      s_tuser,
    input  wire lpct_sts_t sts_i,
    output lpct_cmd_t      cmd_o
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        unique case (state_reg)
            ST_INIT: begin
                cmd_o.sweep      = 1'b1;
                cmd_o.fill_const = 1'b1;
                if (sts_i.pos_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd_o.load_item = 1'b1;
                    if (s_tuser == ACTION_CLEAR) begin
                        state_next = ST_CLEAR;
                    end else begin
                        cmd_o.mod_start = 1'b1;
                        state_next      = ST_MOD;
                    end
                end
            end
            ST_CLEAR: begin
                cmd_o.sweep = 1'b1;
                if (sts_i.pos_last) begin
                    cmd_o.res_clear = 1'b1;
                    state_next      = ST_OUT;
                end
            end
            ST_MOD: begin
                if (sts_i.mod_done) begin
                    cmd_o.pos_load = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts_i.is_empty || sts_i.is_match) begin
                    cmd_o.commit = 1'b1;
                    state_next   = ST_OUT;
                end else if (sts_i.last_probe) begin
                    cmd_o.set_full = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    cmd_o.probe_next = 1'b1;
                end
            end
            ST_OUT: begin
                if (sts_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    a_mod_done_in_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        sts_i.mod_done |-> (state_reg == ST_MOD))
        else $error("hash reduction finished outside its wait state");

    a_incr_starts_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == ACTION_INCR) |=> (state_reg == ST_MOD))
        else $error("increment item did not start hash reduction");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.out_load |=> (state_reg == ST_IDLE && !cmd_o.out_load))
        else $error("result handed off twice");

endmodule

`default_nettype wire

// ===== sv/linear_probe_count_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_count_table
// Counting hash table with open addressing and linear probing.
//
//   channel   handshake             payload
//   s_        s_tvalid / s_tready   tdata: kmer_key, hash_code; tuser: action
//   m_        m_tvalid / m_tready   tdata: slot_index, count_after;
//                                   tuser: status, new_entry
//   cfg_      cfg_wen               cfg_wdata: empty_marker
//
// Increment: intake, hash reduction (the low bits for a power-of-two
// NUM_SLOTS, else the hash folded a byte a cycle, the sum reduced by
// reciprocal multiplication and one compare and subtract, then handed
// over), one slot probed a cycle through the registered memory read
// port, and the result loaded. Clear item: a sweep, one slot a cycle.
// After reset a sweep fills the table; no item is
// taken during it, configuration writes are.
// A stalled result waits in the output register; the next item is taken
// and worked while it waits, and hand-off waits for the register to free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_count_table
    import lpct_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_wen,
    input  wire logic [KEY_W-1:0]     cfg_wdata,   // empty_marker

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,     // kmer_key[63:0], hash_code[127:64]
    input  wire logic                 s_tuser,     // action[0]

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,     // slot_index[9:0], count_after[25:10]
    output logic [M_TUSER_W-1:0]      m_tuser      // status[0], new_entry[1]
);

    lpct_cmd_t cmd;
    lpct_sts_t sts;

    lpct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts_i    (sts),
        .cmd_o    (cmd)
    );

    lpct_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd_i     (cmd),
        .sts_o     (sts)
    );

endmodule

`default_nettype wire

// ===== dv/tb_linear_probe_count_table.sv =====
// ----------------------------------------------------------------------------
// tb_linear_probe_count_table
// Self-checking bench for the linear probing count table. A scoreboard
// class keeps its own copy of the slot keys, the counts and the empty
// marker, predicts the result of every accepted item and compares each
// accepted result field by field. Stimulus covers these cases:
//   - a directed part: field extremes, wrap of the probe at the table end,
//     a key equal to the marker, a marker change over live data and
//     clears
//   - a long run of one key with no idling
//   - random phases under several marker settings
// Both sides idle at random, with some phases where neither side idles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import lpct_pkg::*;

localparam int unsigned TB_SLOTS = 1024;

typedef struct packed {
    logic               status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
    logic               fresh;
} slot_result_t;

class slot_count_tracker;
    logic [KEY_W-1:0]   marker;
    logic [KEY_W-1:0]   keys [TB_SLOTS];
    logic [COUNT_W-1:0] counts [TB_SLOTS];
    slot_result_t       due_results [$];
    int                 errors;

    function new();
        marker = MARKER_RESET;
        errors = 0;
        wipe();
    endfunction

    function void wipe();
        int i;
        for (i = 0; i < TB_SLOTS; i++) begin
            keys[i]   = marker;
            counts[i] = '0;
        end
    endfunction

    function void take_item(logic act, logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash);
        slot_result_t r;
        int unsigned  pos;
        int unsigned  n;
        bit           done;
        r    = '0;
        done = 1'b0;
        if (act == ACTION_CLEAR) begin
            wipe();
        end else begin
            pos = int'(hash % TB_SLOTS);
            for (n = 0; n < TB_SLOTS && !done; n++) begin
                if (keys[pos] == marker) begin
                    keys[pos]   = key;
                    counts[pos] = COUNT_ONE;
                    r.slot      = SLOT_W'(pos);
                    r.count     = COUNT_ONE;
                    r.fresh     = 1'b1;
                    done        = 1'b1;
                end else if (keys[pos] == key) begin
                    if (counts[pos] != COUNT_MAX) begin
                        counts[pos] = counts[pos] + COUNT_ONE;
                    end
                    r.slot  = SLOT_W'(pos);
                    r.count = counts[pos];
                    done    = 1'b1;
                end else begin
                    pos = (pos + 1) % TB_SLOTS;
                end
            end
            if (!done) begin
                r.status = STATUS_FULL;
            end
        end
        due_results.push_back(r);
    endfunction

    function void match_result(slot_result_t got);
        slot_result_t want;
        if (due_results.size() == 0) begin
            $error("result with no item pending: slot_index %0d count_after %0d",
                   got.slot, got.count);
            errors++;
            return;
        end
        want = due_results.pop_front();
        if (got.status != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
        end
        if (got.slot != want.slot) begin
            $error("slot_index: expected %0d, actual %0d", want.slot, got.slot);
            errors++;
        end
        if (got.count != want.count) begin
            $error("count_after: expected %0d, actual %0d", want.count, got.count);
            errors++;
        end
        if (got.fresh != want.fresh) begin
            $error("new_entry: expected %0d, actual %0d", want.fresh, got.fresh);
            errors++;
        end
    endfunction
endclass

module tb_linear_probe_count_table;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned TAIL_CYCLES    = 100;
    localparam int unsigned KEY_POOL       = 64;
    localparam int unsigned PHASE_ITEMS    = 200;
    localparam int unsigned SAT_ITEMS      = 60;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 cfg_wen  = 1'b0;
    logic [KEY_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    slot_count_tracker    sb = new();
    bit                   calm = 1'b0;
    int unsigned          quiet_cycles = 0;
    logic [KEY_W-1:0]     pool_key  [KEY_POOL];
    logic [SLOT_W-1:0]    pool_slot [KEY_POOL];

    linear_probe_count_table #(
        .NUM_SLOTS (TB_SLOTS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 7);
    end

    always @(posedge aclk) begin
        slot_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser[0];
            got.fresh  = m_tuser[1];
            got.slot   = m_tdata[SLOT_W-1:0];
            got.count  = m_tdata[SLOT_W +: COUNT_W];
            sb.match_result(got);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic act, input logic [KEY_W-1:0] key,
                             input logic [HASH_W-1:0] hash);
        while (!calm && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hash, key};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        sb.take_item(act, key, hash);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_marker(input logic [KEY_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        sb.marker = value;
    endtask

    task automatic send_random_item();
        int unsigned      r;
        int unsigned      pick;
        logic [KEY_W-1:0] key;
        logic [HASH_W-1:0] hash;
        r    = $urandom_range(99);
        key  = {$urandom, $urandom};
        hash = {$urandom, $urandom};
        if (r < 2) begin
            send_item(ACTION_CLEAR, key, hash);
        end else if (r < 5) begin
            send_item(ACTION_INCR, sb.marker, hash);
        end else if (r < 82) begin
            pick = $urandom_range(KEY_POOL - 1);
            hash[SLOT_W-1:0] = pool_slot[pick];
            send_item(ACTION_INCR, pool_key[pick], hash);
        end else begin
            send_item(ACTION_INCR, key, hash);
        end
    endtask

    initial begin
        logic [KEY_W-1:0] sat_key;
        logic [KEY_W-1:0] phase_marker;
        int               i;
        int               ph;

        for (i = 0; i < KEY_POOL; i++) begin
            pool_key[i] = {$urandom, $urandom};
            if (i < 24) begin
                pool_slot[i] = SLOT_W'($urandom_range(15));
            end else if (i < 32) begin
                pool_slot[i] = SLOT_W'($urandom_range(TB_SLOTS - 1, TB_SLOTS - 8));
            end else begin
                pool_slot[i] = SLOT_W'($urandom_range(TB_SLOTS - 1));
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // insert, bump, wrap past the last slot, key equal to the marker
        send_item(ACTION_INCR, '0, '0);
        send_item(ACTION_INCR, '0, '0);
        send_item(ACTION_INCR, '1, '1);
        send_item(ACTION_INCR, {$urandom, $urandom}, HASH_W'(TB_SLOTS - 1));
        send_item(ACTION_INCR, '0, HASH_W'(TB_SLOTS - 1));
        send_item(ACTION_INCR, MARKER_RESET, HASH_W'(5));
        send_item(ACTION_INCR, MARKER_RESET, HASH_W'(5));
        send_item(ACTION_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
        send_item(ACTION_INCR, '0, '0);
        wait_drained();

        // old marker left in place: slot 0 reads empty, the rest occupied
        write_marker('0);
        send_item(ACTION_INCR, KEY_W'(123), HASH_W'(7));
        send_item(ACTION_INCR, KEY_W'(456), HASH_W'(7));
        send_item(ACTION_INCR, MARKER_RESET, HASH_W'(9));
        send_item(ACTION_CLEAR, '1, '1);
        send_item(ACTION_INCR, '0, HASH_W'(3));
        send_item(ACTION_INCR, '1, HASH_W'(3));
        wait_drained();

        write_marker('1);
        send_item(ACTION_CLEAR, '0, '0);
        send_item(ACTION_INCR, '1, HASH_W'(100));
        send_item(ACTION_INCR, '0, HASH_W'(100));
        send_item(ACTION_INCR, '0, {$urandom, $urandom});
        wait_drained();

        // repeat one key
        write_marker({$urandom, $urandom});
        send_item(ACTION_CLEAR, '0, '0);
        calm = 1'b1;
        sat_key = {$urandom, $urandom};
        phase_marker = {$urandom, $urandom};
        for (i = 0; i < SAT_ITEMS; i++) begin
            send_item(ACTION_INCR, sat_key, phase_marker);
        end
        calm = 1'b0;
        wait_drained();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: phase_marker = '0;
                1: phase_marker = '1;
                2: phase_marker = {$urandom, $urandom};
                default: phase_marker = MARKER_RESET;
            endcase
            write_marker(phase_marker);
            send_item(ACTION_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
            calm = (ph == 2);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                send_random_item();
            end
            calm = 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
